FILE: hdl/shift_and_pattern_matcher_macros.svh
// ----------------------------------------------------------------------------
// Shift-And matcher assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHIFT_AND_PATTERN_MATCHER_MACROS_SVH
`define SHIFT_AND_PATTERN_MATCHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/smm_pkg.sv
// ----------------------------------------------------------------------------
// Shift-And matcher package
// Sizes, input kind codes, internal operation codes and the queue entry type.
// ----------------------------------------------------------------------------
package smm_pkg;

  // Longest pattern and number of character rows in the mask table.
  localparam int PATTERN_MAX = 64;
  localparam int ALPHABET    = 128;

  // Field widths of the channels.
  localparam int KIND_W = 2;
  localparam int CH_W   = 7;

  // Derived widths.
  localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int ADDR_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int LIM_W  = CH_W + 2;

  // Decoupling queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input kind codes.
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCAN   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RSVD   = 2'd3;

  // Classified operation carried through the queue.
  typedef enum logic [1:0] {
    OP_NOP,
    OP_CLEAR,
    OP_APPEND,
    OP_SCAN
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [CH_W-1:0] ch;
  } q_item_t;

endpackage

FILE: hdl/smm_stream_if.sv
// ----------------------------------------------------------------------------
// Shift-And matcher channel interfaces
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface smm_in_if import smm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CH_W-1:0]   ch;

  modport source (output valid, output kind, output ch, input ready);
  modport sink   (input valid, input kind, input ch, output ready);
endinterface

interface smm_out_if;
  logic valid;
  logic ready;
  logic match_here;
  logic found;
  logic overflow;

  modport source (output valid, output match_here, output found, output overflow,
                  input ready);
  modport sink   (input valid, input match_here, input found, input overflow,
                  output ready);
endinterface

FILE: hdl/smm_front.sv
// ----------------------------------------------------------------------------
// Shift-And matcher front end
// Accepts input items, classifies the kind code and queues them for the back.
// ----------------------------------------------------------------------------
`include "shift_and_pattern_matcher_macros.svh"

module smm_front import smm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  smm_in_if.sink     in_ch,
  output logic       q_valid,
  output q_item_t    q_item,
  input  logic       q_pop
);

  q_item_t             q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                push;
  op_t                 op_dec;

  // Space is left whenever the queue is not full.
  assign in_ch.ready = (count_r != QCNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  // Classify the kind code; the reserved code does nothing.
  always_comb begin
    unique case (in_ch.kind)
      KIND_CLEAR:  op_dec = OP_CLEAR;
      KIND_APPEND: op_dec = OP_APPEND;
      KIND_SCAN:   op_dec = OP_SCAN;
      KIND_RSVD:   op_dec = OP_NOP;
      default:     op_dec = OP_NOP;
    endcase
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{op: op_dec, ch: in_ch.ch};
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !q_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (!push && q_pop) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  assign q_valid = (count_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];

  `SMM_ASSERT_SAME(a_cnt_bound, 1'b1, count_r <= QCNT_W'(QDEPTH), "queue count overran")
  `SMM_ASSERT_SAME(a_pop_nonempty, q_pop, count_r != '0, "pop from empty queue")
  `SMM_ASSERT_NEXT(a_push_count, push && !q_pop, count_r == $past(count_r) + QCNT_W'(1),
                   "queue count did not grow on push")

endmodule

FILE: hdl/smm_back.sv
// ----------------------------------------------------------------------------
// Shift-And matcher back end
// Holds the mask table and pattern length, reads the character row, then
// advances the active vector and registers the result.
// ----------------------------------------------------------------------------
`include "shift_and_pattern_matcher_macros.svh"

module smm_back import smm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  q_item_t    q_item,
  output logic       q_pop,
  smm_out_if.source  out_ch
);

  localparam logic [LIM_W-1:0] ALPHA_LIM = LIM_W'(ALPHABET);

  // Mask table with one valid bit per row; an invalid row reads as zero.
  logic [PATTERN_MAX-1:0] mask_mem [ALPHABET];
  logic [ALPHABET-1:0]    row_vld_r;

  // Pattern state, owned by the issue stage.
  logic [LEN_W-1:0]       len_r;
  logic [LEN_W-1:0]       len_nxt;
  logic                   ovf_r;
  logic                   ovf_nxt;

  // Issue stage register.
  logic                   a_valid_r;
  op_t                    a_op_r;
  logic [LEN_W-1:0]       a_len_r;
  logic                   a_ovf_r;
  logic [PATTERN_MAX-1:0] rd_row_r;
  logic                   rd_vld_r;

  // Execute state and result register.
  logic [PATTERN_MAX-1:0] active_r;
  logic [PATTERN_MAX-1:0] active_nxt;
  logic                   found_r;
  logic                   found_nxt;
  logic                   hit;
  logic                   out_valid_r;
  logic                   out_match_r;
  logic                   out_found_r;
  logic                   out_ovf_r;

  logic                   a_adv;
  logic                   in_alpha;
  logic [ADDR_W-1:0]      addr;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [PATTERN_MAX-1:0] row;
  logic [IDX_W-1:0]       tail_idx;

  // Pipeline flow: the result register frees the issue stage.
  assign a_adv = a_valid_r && (!out_valid_r || out_ch.ready);
  assign q_pop = q_valid && (!a_valid_r || a_adv);

  assign in_alpha = ({2'b00, q_item.ch} < ALPHA_LIM);
  assign addr     = ADDR_W'(q_item.ch);
  assign wr_idx   = IDX_W'(len_r);

  // Pattern length and overflow updates at issue.
  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    wr_en   = 1'b0;
    unique case (q_item.op)
      OP_CLEAR: begin
        len_nxt = '0;
        ovf_nxt = 1'b0;
      end
      OP_APPEND: begin
        if (len_r == LEN_W'(PATTERN_MAX)) begin
          ovf_nxt = 1'b1;
        end else begin
          len_nxt = len_r + LEN_W'(1);
          wr_en   = in_alpha;
        end
      end
      OP_SCAN, OP_NOP: begin
        len_nxt = len_r;
      end
      default: begin
        len_nxt = len_r;
      end
    endcase
  end

  // Mask table: set one bit per append; a fresh row starts from zero.
  always_ff @(posedge clk) begin
    if (q_pop && wr_en) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        if (!row_vld_r[addr] || (IDX_W'(i) == wr_idx)) begin
          mask_mem[addr][i] <= (IDX_W'(i) == wr_idx);
        end
      end
    end
  end

  // Registered row read for the item entering the issue stage.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_row_r <= mask_mem[addr];
      rd_vld_r <= row_vld_r[addr] && in_alpha;
      a_op_r   <= q_item.op;
      a_len_r  <= len_nxt;
      a_ovf_r  <= ovf_nxt;
    end
  end

  // Issue stage control state and row valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      len_r     <= '0;
      ovf_r     <= 1'b0;
      row_vld_r <= '0;
    end else begin
      if (q_pop) begin
        a_valid_r <= 1'b1;
        len_r     <= len_nxt;
        ovf_r     <= ovf_nxt;
        if (q_item.op == OP_CLEAR) begin
          row_vld_r <= '0;
        end else if (wr_en) begin
          row_vld_r[addr] <= 1'b1;
        end
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
    end
  end

  assign row      = rd_vld_r ? rd_row_r : '0;
  assign tail_idx = IDX_W'(a_len_r - LEN_W'(1));

  // Shift-And step on the active vector.
  always_comb begin
    active_nxt = active_r;
    found_nxt  = found_r;
    hit        = 1'b0;
    unique case (a_op_r)
      OP_CLEAR: begin
        active_nxt = '0;
        found_nxt  = 1'b0;
      end
      OP_SCAN: begin
        active_nxt = ((active_r << 1) | PATTERN_MAX'(1)) & row;
        hit        = (a_len_r != '0) && !a_ovf_r && active_nxt[tail_idx];
        found_nxt  = found_r || hit;
      end
      OP_APPEND, OP_NOP: begin
        active_nxt = active_r;
      end
      default: begin
        active_nxt = active_r;
      end
    endcase
  end

  // Execute state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_adv) begin
        active_r    <= active_nxt;
        found_r     <= found_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (a_adv) begin
      out_match_r <= hit;
      out_found_r <= found_nxt;
      out_ovf_r   <= a_ovf_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.match_here = out_match_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.overflow   = out_ovf_r;

  `SMM_ASSERT_SAME(a_hit_scan, hit && a_adv, (a_op_r == OP_SCAN) && (a_len_r != '0),
                   "match outside a scan of a non-empty pattern")
  `SMM_ASSERT_SAME(a_found_fall, $fell(found_r), $past(a_adv && (a_op_r == OP_CLEAR)),
                   "found flag dropped without a clear")
  `SMM_ASSERT_NEXT(a_adv_out, a_adv, out_valid_r, "advanced item produced no result")
  `SMM_ASSERT_SAME(a_ovf_full, ovf_r, len_r == LEN_W'(PATTERN_MAX),
                   "overflow set while pattern not full")

endmodule

FILE: hdl/shift_and_pattern_matcher.sv
// ----------------------------------------------------------------------------
// Shift-And pattern matcher
// Exact string matcher with a streamed pattern and text, one result per item.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on in_ch (kind, ch) and each gives one result on out_ch
// (match_here, found, overflow). A transfer happens at a clock edge with
// valid and ready both high. Kind clear empties the pattern, the mask table
// and both flags; kind append adds one pattern character, or sets overflow
// once the pattern is full; kind scan feeds one text character and reports
// a match ending at it. Each item is queued, then registered with its mask
// table row in the issue stage, then in the result register. Throughput: one
// item per cycle while out_ch takes results, with the shift-and-AND step.
// A four-entry queue sits between the input and the table stage, so input
// keeps flowing while out_ch is stalled; the result register
// holds its item until it is taken, and in_ch.ready falls once the queue fills.
// Reset (rst_n low, synchronous) empties the queue and the pipeline and
// clears the pattern, the mask table and the flags at once; no clearing pass.
// ----------------------------------------------------------------------------
module shift_and_pattern_matcher import smm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  smm_in_if.sink     in_ch,
  smm_out_if.source  out_ch
);

  logic    q_valid;
  logic    q_pop;
  q_item_t q_item;

  // Front end: accept, classify and queue.
  smm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // Back end: mask table, active vector and result register.
  smm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shift-And pattern matcher testbench
// Runs a short table of hand-picked items and then random clear, pattern and
// text sequences through the matcher, with random idle and stall bursts. Each
// result is checked against its typed row or an in-bench bit-parallel matcher.
// ----------------------------------------------------------------------------
module testbench import smm_pkg::*; ();

  // Flags of one result transfer.
  typedef struct packed {
    logic match_here;
    logic found;
    logic overflow;
  } hit_flags_t;

  // One row of the opening table; typed rows carry their own expectation.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   ch;
    bit                typed;
    hit_flags_t        want;
  } probe_row_t;

  localparam int OPENING_LEN = 21;
  localparam int ITEM_GOAL   = 950;
  localparam int CALM_AFTER  = 850;

  logic clk = 1'b0;
  logic rst_n;

  smm_in_if  in_ch ();
  smm_out_if out_ch ();

  shift_and_pattern_matcher dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Matcher state mirrored in the bench.
  logic [PATTERN_MAX-1:0] row_bits [ALPHABET];
  logic [PATTERN_MAX-1:0] live_vec;
  logic [LEN_W-1:0]       pat_len;
  logic                   seen_flag;
  logic                   too_long_flag;

  hit_flags_t verdict_q [$];
  int         mismatches = 0;
  int         sent = 0;
  bit         calm = 1'b0;
  bit         idle_on = 1'b0;
  int         stall_left = 0;

  probe_row_t opening_rows [OPENING_LEN] = '{
    '{KIND_SCAN,   7'd0,   1'b1, 3'b000},  // empty pattern right after reset
    '{KIND_SCAN,   7'd127, 1'b1, 3'b000},
    '{KIND_RSVD,   7'd127, 1'b1, 3'b000},  // unused kind does nothing
    '{KIND_APPEND, 7'd0,   1'b1, 3'b000},
    '{KIND_APPEND, 7'd127, 1'b1, 3'b000},
    '{KIND_SCAN,   7'd0,   1'b0, 3'b000},
    '{KIND_SCAN,   7'd127, 1'b0, 3'b000},
    '{KIND_SCAN,   7'd127, 1'b0, 3'b000},
    '{KIND_RSVD,   7'd0,   1'b0, 3'b000},  // found must survive an unused kind
    '{KIND_CLEAR,  7'd127, 1'b1, 3'b000},
    '{KIND_APPEND, 7'd85,  1'b1, 3'b000},
    '{KIND_SCAN,   7'd85,  1'b0, 3'b000},
    '{KIND_SCAN,   7'd85,  1'b0, 3'b000},
    '{KIND_SCAN,   7'd42,  1'b0, 3'b000},
    '{KIND_CLEAR,  7'd0,   1'b1, 3'b000},
    '{KIND_APPEND, 7'd42,  1'b1, 3'b000},
    '{KIND_APPEND, 7'd42,  1'b1, 3'b000},
    '{KIND_SCAN,   7'd42,  1'b0, 3'b000},  // overlapping occurrences
    '{KIND_SCAN,   7'd42,  1'b0, 3'b000},
    '{KIND_SCAN,   7'd42,  1'b0, 3'b000},
    '{KIND_CLEAR,  7'd85,  1'b1, 3'b000}
  };

  // Clock.
  always #5 clk = ~clk;

  // Advance the mirrored matcher by one item and return its flags.
  function automatic hit_flags_t bitap_step(input logic [KIND_W-1:0] kind,
                                            input logic [CH_W-1:0] ch);
    hit_flags_t v;
    logic       hit;
    hit = 1'b0;
    case (kind)
      KIND_CLEAR: begin
        for (int r = 0; r < ALPHABET; r++) row_bits[r] = '0;
        live_vec      = '0;
        pat_len       = '0;
        seen_flag     = 1'b0;
        too_long_flag = 1'b0;
      end
      KIND_APPEND: begin
        if (int'(pat_len) >= PATTERN_MAX) begin
          too_long_flag = 1'b1;
        end else begin
          row_bits[ch][int'(pat_len)] = 1'b1;
          pat_len = pat_len + 1'b1;
        end
      end
      KIND_SCAN: begin
        live_vec = ((live_vec << 1) | PATTERN_MAX'(1)) & row_bits[ch];
        if (pat_len != '0 && !too_long_flag) hit = live_vec[int'(pat_len) - 1];
        if (hit) seen_flag = 1'b1;
      end
      default: ;
    endcase
    v.match_here = hit;
    v.found      = seen_flag;
    v.overflow   = too_long_flag;
    return v;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string msg);
    $display("%0t: MISMATCH %s", $realtime, msg);
    mismatches++;
  endtask

  // Offer one item, wait for its transfer and record what it must produce.
  task automatic push_item(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch,
                           input bit typed, input hit_flags_t want);
    hit_flags_t v;
    if (!calm && idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.ch    <= ch;
    do @(posedge clk); while (!in_ch.ready);
    v = bitap_step(kind, ch);
    verdict_q.push_back(typed ? want : v);
    sent++;
    calm <= (sent >= CALM_AFTER);
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  // One clear / pattern / text sequence, or a short burst of arbitrary items.
  task automatic run_sequence(input int seq_no);
    logic [CH_W-1:0] sym [3];
    logic [CH_W-1:0] pat [$];
    logic [CH_W-1:0] c;
    int              plen;
    int              tlen;
    int              k;
    int              pick;
    idle_on <= ($urandom_range(0, 1) == 1);
    for (int i = 0; i < 3; i++) sym[i] = CH_W'($urandom_range(0, 127));

    // Arbitrary items: any kind, any character, no preceding clear.
    if (seq_no >= 2 && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 8))
        push_item(KIND_W'($urandom_range(0, 3)), CH_W'($urandom_range(0, 127)),
                  1'b0, '0);
      return;
    end

    // Pattern length: overflow first, then a full-length pattern, then mostly short.
    if (seq_no == 0) plen = PATTERN_MAX + 2;
    else if (seq_no == 1) plen = PATTERN_MAX;
    else begin
      pick = $urandom_range(0, 19);
      if (pick == 0) plen = $urandom_range(PATTERN_MAX, PATTERN_MAX + 3);
      else if (pick == 1) plen = $urandom_range(20, PATTERN_MAX - 1);
      else plen = $urandom_range(1, 6);
    end

    push_item(KIND_CLEAR, CH_W'($urandom_range(0, 127)), 1'b0, '0);
    for (int i = 0; i < plen; i++) begin
      c = sym[$urandom_range(0, 2)];
      pat.push_back(c);
      push_item(KIND_APPEND, c, 1'b0, '0);
    end

    // Text: pattern symbols, embedded copies of the pattern and some noise.
    if (seq_no == 1) foreach (pat[i]) push_item(KIND_SCAN, pat[i], 1'b0, '0);
    tlen = (plen > 8) ? plen + $urandom_range(4, 20) : $urandom_range(8, 40);
    k = 0;
    while (k < tlen) begin
      pick = $urandom_range(0, 19);
      if (pick < 4) begin
        foreach (pat[i]) push_item(KIND_SCAN, pat[i], 1'b0, '0);
        k += pat.size();
      end else if (pick == 4) begin
        push_item(KIND_SCAN, CH_W'($urandom_range(0, 127)), 1'b0, '0);
        k++;
      end else if (pick == 5) begin
        push_item(KIND_RSVD, CH_W'($urandom_range(0, 127)), 1'b0, '0);
        k++;
      end else if (pick == 6) begin
        // Growing the pattern in the middle of the text.
        c = sym[$urandom_range(0, 2)];
        pat.push_back(c);
        push_item(KIND_APPEND, c, 1'b0, '0);
        k++;
      end else begin
        push_item(KIND_SCAN, sym[$urandom_range(0, 2)], 1'b0, '0);
        k++;
      end
    end
  endtask

  // Result side: random stall bursts and a field-by-field check of each transfer.
  always @(posedge clk) begin
    hit_flags_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          want = verdict_q.pop_front();
          if (out_ch.match_here !== want.match_here)
            report_mismatch($sformatf("match_here got %b want %b",
                                      out_ch.match_here, want.match_here));
          if (out_ch.found !== want.found)
            report_mismatch($sformatf("found got %b want %b", out_ch.found, want.found));
          if (out_ch.overflow !== want.overflow)
            report_mismatch($sformatf("overflow got %b want %b",
                                      out_ch.overflow, want.overflow));
        end
      end
      if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left   <= $urandom_range(0, 13);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int seq_no;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_CLEAR;
    in_ch.ch     = '0;
    out_ch.ready = 1'b0;
    for (int r = 0; r < ALPHABET; r++) row_bits[r] = '0;
    live_vec      = '0;
    pat_len       = '0;
    seen_flag     = 1'b0;
    too_long_flag = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening table.
    foreach (opening_rows[i])
      push_item(opening_rows[i].kind, opening_rows[i].ch, opening_rows[i].typed,
                opening_rows[i].want);
    hold_until_drained();

    // Random sequences, with an occasional full drain in between.
    seq_no = 0;
    while (sent < ITEM_GOAL) begin
      run_sequence(seq_no);
      seq_no++;
      if (!calm && $urandom_range(0, 11) == 0) hold_until_drained();
    end

    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/smm_pkg.sv
hdl/smm_stream_if.sv
hdl/smm_front.sv
hdl/smm_back.sv
hdl/shift_and_pattern_matcher.sv
tb/testbench.sv
